FILE: design/timed_event_queue_core_assert.svh
// assertion macros shared by the timed event queue rtl
// expects clk and rst_n in the scope where the macros are used
`ifndef TIMED_EVENT_QUEUE_CORE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_CORE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define TEQ_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define TEQ_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/teq_pkg.sv
// shared types, codes and helpers for the timed event queue
// no dependencies
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_OUT     = 16;
  localparam int POS_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NOUT_W      = $clog2(MAX_OUT);

  localparam int KIND_W   = 2;
  localparam int DELAY_W  = 24;
  localparam int SERIAL_W = 32;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_POST   = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } teq_kind_t;

  localparam logic [STATUS_W-1:0] ST_POSTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch accepted beat
    logic scan;        // register search mask
    logic exec;        // apply post or cancel, load result
    logic emit;        // pop head as expired result
    logic force_last;  // emit is the final one allowed for this tick
  } teq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_due;    // queue not empty and head is due
    logic emit_last;   // an emit now would be the final result
    logic out_free;    // result register can take a beat
  } teq_status_t;

  // a at or before b, wrapping signed difference
  function automatic logic not_later(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d == '0) || d[TIME_W-1];
  endfunction

endpackage

FILE: design/teq_ctrl.sv
// controller state machine for the timed event queue
// depends on teq_pkg
module teq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [teq_pkg::KIND_W-1:0]   in_kind,
  output logic                         in_ready,
  input  teq_pkg::teq_status_t         st,
  output teq_pkg::teq_cmd_t            cmd
);
  import teq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_TICK = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NOUT_W-1:0]   nout_r, nout_nxt;

  always_comb begin
    state_nxt = state_r;
    nout_nxt  = nout_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (teq_kind_t'(in_kind))
            KIND_POST, KIND_CANCEL: state_nxt = S_SCAN;
            KIND_TICK: begin
              state_nxt = S_TICK;
              nout_nxt  = '0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (st.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (!st.head_due) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit       = 1'b1;
          cmd.force_last = (nout_r == NOUT_W'(MAX_OUT - 1));
          nout_nxt       = nout_r + 1'b1;
          if (st.emit_last || cmd.force_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nout_r  <= '0;
    end else begin
      state_r <= state_nxt;
      nout_r  <= nout_nxt;
    end
  end

endmodule

FILE: design/teq_datapath.sv
// sorted entry store, search masks, time and serial counters, result register
// depends on teq_pkg and timed_event_queue_core_assert.svh
`include "timed_event_queue_core_assert.svh"
module teq_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [teq_pkg::KIND_W-1:0]     in_kind,
  input  logic [teq_pkg::DELAY_W-1:0]    in_delay,
  input  logic [teq_pkg::SERIAL_W-1:0]   in_cancel_serial,
  input  teq_pkg::teq_cmd_t              cmd,
  output teq_pkg::teq_status_t           st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [teq_pkg::STATUS_W-1:0]   out_status,
  output logic [teq_pkg::SERIAL_W-1:0]   out_event_serial,
  output logic                           out_last
);
  import teq_pkg::*;

  logic [TIME_W-1:0]   due_r  [QUEUE_DEPTH];
  logic [SERIAL_W-1:0] ser_r  [QUEUE_DEPTH];
  logic [TIME_W-1:0]   due_prev [QUEUE_DEPTH];
  logic [SERIAL_W-1:0] ser_prev [QUEUE_DEPTH];
  logic [TIME_W-1:0]   due_next [QUEUE_DEPTH];
  logic [SERIAL_W-1:0] ser_next [QUEUE_DEPTH];

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [SERIAL_W-1:0] serial_r, serial_nxt;
  logic [KIND_W-1:0]   kind_r;
  logic [TIME_W-1:0]   due_new_r;
  logic [SERIAL_W-1:0] wanted_r;
  logic [QUEUE_DEPTH-1:0] mask_r, mask_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SERIAL_W-1:0] out_serial_r;
  logic                out_last_r;

  logic [POS_W-1:0]    hit_pos;
  logic                hit;
  logic                full;
  logic                do_insert, do_remove;
  logic [POS_W-1:0]    rm_pos;

  // neighbor views for shifting
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      due_prev[i] = '0;
      ser_prev[i] = '0;
      due_next[i] = due_r[i];
      ser_next[i] = ser_r[i];
    end
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      due_prev[i]   = due_r[i-1];
      ser_prev[i]   = ser_r[i-1];
      due_next[i-1] = due_r[i];
      ser_next[i-1] = ser_r[i];
    end
  end

  // per-slot compare: post wants first slot not at or before new due,
  // cancel wants first slot holding the serial
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (teq_kind_t'(kind_r) == KIND_POST)
        mask_nxt[i] = !((CNT_W'(i) < count_r) && not_later(due_r[i], due_new_r));
      else
        mask_nxt[i] = (CNT_W'(i) < count_r) && (ser_r[i] == wanted_r);
    end
  end

  // first set bit of registered mask
  always_comb begin
    hit_pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (mask_r[i]) hit_pos = POS_W'(i);
    end
    hit = |mask_r;
  end

  assign full      = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign do_insert = cmd.exec && (teq_kind_t'(kind_r) == KIND_POST) && !full;
  assign do_remove = cmd.emit ||
                     (cmd.exec && (teq_kind_t'(kind_r) == KIND_CANCEL) && hit);
  assign rm_pos    = cmd.emit ? '0 : hit_pos;

  assign st.out_free  = !out_valid_r || out_ready;
  assign st.head_due  = (count_r != '0) && not_later(due_r[0], time_r);
  assign st.emit_last = (count_r == CNT_W'(1)) || !not_later(due_r[1], time_r);

  always_comb begin
    count_nxt     = count_r;
    time_nxt      = time_r;
    serial_nxt    = serial_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load && (teq_kind_t'(in_kind) == KIND_TICK)) time_nxt = time_r + 1'b1;
    if (do_insert) begin
      count_nxt  = count_r + 1'b1;
      serial_nxt = serial_r + 1'b1;
    end
    if (do_remove) count_nxt = count_r - 1'b1;
    if (cmd.exec || cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      time_r      <= '0;
      serial_r    <= SERIAL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      serial_r    <= serial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      due_new_r <= time_r + TIME_W'(in_delay);
      wanted_r  <= in_cancel_serial;
    end
    if (cmd.scan) mask_r <= mask_nxt;

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_insert) begin
        if (POS_W'(i) == hit_pos) begin
          due_r[i] <= due_new_r;
          ser_r[i] <= serial_r;
        end else if (POS_W'(i) > hit_pos) begin
          due_r[i] <= due_prev[i];
          ser_r[i] <= ser_prev[i];
        end
      end else if (do_remove) begin
        if (POS_W'(i) >= rm_pos) begin
          due_r[i] <= due_next[i];
          ser_r[i] <= ser_next[i];
        end
      end
    end

    if (cmd.exec) begin
      out_last_r <= 1'b1;
      case (teq_kind_t'(kind_r))
        KIND_POST: begin
          out_status_r <= full ? ST_FULL : ST_POSTED;
          out_serial_r <= full ? '0 : serial_r;
        end
        default: begin
          out_status_r <= hit ? ST_CANCELLED : ST_NOT_FOUND;
          out_serial_r <= wanted_r;
        end
      endcase
    end else if (cmd.emit) begin
      out_status_r <= ST_EXPIRED;
      out_serial_r <= ser_r[0];
      out_last_r   <= st.emit_last || cmd.force_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_event_serial = out_serial_r;
  assign out_last         = out_last_r;

  `TEQ_ALWAYS(a_count_range, count_r <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `TEQ_IMPLY(a_load_slot_free, cmd.exec || cmd.emit, st.out_free, "result loaded over pending beat")
  `TEQ_IMPLY(a_emit_due, cmd.emit, st.head_due, "expired beat without a due head")
  `TEQ_IMPLY(a_insert_room, do_insert, count_r < CNT_W'(QUEUE_DEPTH), "insert into full queue")

endmodule

FILE: design/timed_event_queue_core.sv
// post / cancel: mask scan, then apply, which loads the result once the result register is free
// tick: n expired beats, then one per cycle while the output takes them, up to 16; the next
// beat is taken after the last expired beat is loaded, or once nothing is due; output stalls delay both
// one item in flight; the next input beat is taken once the current item's results are loaded
// sync active-low reset: empty queue, time 0, next serial 1, no result pending
// entry store has no reset; slots at or past the entry count are never read
module timed_event_queue_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [teq_pkg::KIND_W-1:0]     in_kind,
  input  logic [teq_pkg::DELAY_W-1:0]    in_delay,
  input  logic [teq_pkg::SERIAL_W-1:0]   in_cancel_serial,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [teq_pkg::STATUS_W-1:0]   out_status,
  output logic [teq_pkg::SERIAL_W-1:0]   out_event_serial,
  output logic                           out_last
);
  import teq_pkg::*;

  // command and status between sequencer and datapath
  teq_cmd_t    cmd;
  teq_status_t st;

  // sequencer: idle, mask scan, apply, and a per-tick pop loop
  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // sorted store shifts in place on insert and remove;
  // the result register lets the next beat in while a result waits
  teq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_delay         (in_delay),
    .in_cancel_serial (in_cancel_serial),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_event_serial (out_event_serial),
    .out_last         (out_last)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// testbench for timed_event_queue_core: posts, cancels and ticks checked against a predictor
// depends on teq_pkg and the core rtl; needs no other file
module tb_top;
  import teq_pkg::*;

  // kind code that the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SERIAL_W-1:0] serial;
    logic                last;
  } result_beat_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind = KIND_TICK;
  logic [DELAY_W-1:0]  in_delay = '0;
  logic [SERIAL_W-1:0] in_cancel_serial = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SERIAL_W-1:0] out_event_serial;
  logic                out_last;

  // predictor state: pending events in due order, front first
  logic [TIME_W-1:0]   pending_due    [QUEUE_DEPTH];
  logic [SERIAL_W-1:0] pending_serial [QUEUE_DEPTH];
  int                  pending_count = 0;
  logic [TIME_W-1:0]   model_now = '0;
  logic [SERIAL_W-1:0] model_next_serial = 1;

  // result beats still owed by the block, oldest first
  result_beat_t expected_beats [$];

  int error_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  timed_event_queue_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_delay         (in_delay),
    .in_cancel_serial (in_cancel_serial),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_event_serial (out_event_serial),
    .out_last         (out_last)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // true when an event due at 'due' has come due at time 'at' (wrapping compare)
  function automatic bit is_due(input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] at);
    logic [TIME_W-1:0] diff;
    diff = due - at;
    return ($signed(diff) <= 0);
  endfunction

  task automatic push_beat(input logic [STATUS_W-1:0] st, input logic [SERIAL_W-1:0] ser,
                           input logic lst);
    result_beat_t b;
    b.status = st;
    b.serial = ser;
    b.last   = lst;
    expected_beats.push_back(b);
  endtask

  // drop the pending entry at slot pos, closing the gap
  task automatic drop_pending(input int pos);
    for (int i = pos; i + 1 < pending_count; i++) begin
      pending_due[i]    = pending_due[i + 1];
      pending_serial[i] = pending_serial[i + 1];
    end
    pending_count--;
  endtask

  // apply one accepted beat to the predicted queue and queue up its results
  task automatic predict_queue_step(input logic [KIND_W-1:0] kind,
                                    input logic [DELAY_W-1:0] dly,
                                    input logic [SERIAL_W-1:0] wanted);
    logic [TIME_W-1:0]   due;
    logic [SERIAL_W-1:0] fired [MAX_OUT];
    int                  pos;
    int                  n;
    bit                  hit;
    case (kind)
      KIND_POST: begin
        if (pending_count >= QUEUE_DEPTH) begin
          push_beat(ST_FULL, '0, 1'b1);
        end else begin
          due = model_now + TIME_W'(dly);
          // goes behind everything due at the same time or earlier
          pos = 0;
          while (pos < pending_count && is_due(pending_due[pos], due)) pos++;
          for (int i = pending_count; i > pos; i--) begin
            pending_due[i]    = pending_due[i - 1];
            pending_serial[i] = pending_serial[i - 1];
          end
          pending_due[pos]    = due;
          pending_serial[pos] = model_next_serial;
          pending_count++;
          push_beat(ST_POSTED, model_next_serial, 1'b1);
          model_next_serial = model_next_serial + 1;
        end
      end
      KIND_CANCEL: begin
        hit = 1'b0;
        for (int i = 0; i < pending_count && !hit; i++) begin
          if (pending_serial[i] == wanted) begin
            drop_pending(i);
            hit = 1'b1;
          end
        end
        push_beat(hit ? ST_CANCELLED : ST_NOT_FOUND, wanted, 1'b1);
      end
      KIND_TICK: begin
        model_now = model_now + 1;
        n = 0;
        while (n < MAX_OUT && pending_count > 0 && is_due(pending_due[0], model_now)) begin
          fired[n] = pending_serial[0];
          drop_pending(0);
          n++;
        end
        for (int i = 0; i < n; i++) push_beat(ST_EXPIRED, fired[i], i == n - 1);
      end
      default: begin
        // unused kind: no state change, no results
      end
    endcase
  endtask

  // offer one beat, hold it until taken, then predict its results
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DELAY_W-1:0] dly,
                           input logic [SERIAL_W-1:0] csr);
    int gap;
    @(negedge clk);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_delay         <= dly;
    in_cancel_serial <= csr;
    do @(posedge clk); while (!in_ready);
    predict_queue_step(kind, dly, csr);
  endtask

  // stop offering, let every owed beat arrive, then allow for trailing work
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // result checker: every taken beat against the oldest expectation
  always @(posedge clk) begin
    result_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: status %0d serial %0d last %0d",
               out_status, out_event_serial, out_last);
        error_count++;
      end else begin
        want = expected_beats[0];
        expected_beats.delete(0);
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
        if (out_event_serial !== want.serial) begin
          $error("event_serial mismatch: expected %0d, actual %0d",
                 want.serial, out_event_serial);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // single operations on an almost empty queue, field extremes, ignored kind
  task automatic test_single_ops();
    logic [SERIAL_W-1:0] far_serial;
    send_item(KIND_TICK, '0, '0);             // nothing due, time still moves
    send_item(KIND_POST, '0, '1);             // leaves on the next tick
    far_serial = model_next_serial;
    send_item(KIND_POST, DELAY_MAX, '0);      // far in the future
    send_item(KIND_CANCEL, '0, '0);           // serial 0 never issued yet
    send_item(KIND_CANCEL, '1, {SERIAL_W{1'b1}});
    send_item(KIND_UNUSED, DELAY_MAX, '1);    // ignored
    send_item(KIND_TICK, DELAY_MAX, '1);      // expires the zero-delay post
    send_item(KIND_CANCEL, '0, far_serial);   // found
    send_item(KIND_CANCEL, '0, far_serial);   // already gone
    drain_results();
  endtask

  // fill to the limit with equal and adjacent due times, refuse one, release all at once
  task automatic test_full_and_burst();
    for (int i = 0; i < QUEUE_DEPTH; i++) send_item(KIND_POST, DELAY_W'($urandom_range(0, 1)), '0);
    send_item(KIND_POST, '0, '0);             // refused, queue full
    send_item(KIND_TICK, '0, '0);             // all sixteen leave, fifo within a due time
    drain_results();
  endtask

  // mixed traffic; cancels mostly aim at live serials so the search hits
  task automatic test_random_traffic(input int count);
    int                  done;
    int                  r;
    logic [DELAY_W-1:0]  dly;
    logic [SERIAL_W-1:0] csr;
    done = 0;
    while (done < count) begin
      r   = $urandom_range(0, 99);
      dly = DELAY_W'($urandom_range(0, 12));
      csr = $urandom;
      if (r < 45) begin
        r = $urandom_range(0, 99);
        if (r >= 95) dly = DELAY_W'($urandom);
        else if (r >= 85) dly = DELAY_W'($urandom_range(13, 300));
        send_item(KIND_POST, dly, csr);
        done++;
      end else if (r < 65) begin
        r = $urandom_range(0, 99);
        if (r < 70 && pending_count > 0)
          csr = pending_serial[$urandom_range(0, pending_count - 1)];
        else if (r < 85)
          csr = model_next_serial - SERIAL_W'($urandom_range(1, 40));
        send_item(KIND_CANCEL, dly, csr);
        done++;
      end else if (r < 95) begin
        send_item(KIND_TICK, dly, csr);
        done++;
      end else begin
        send_item(KIND_UNUSED, DELAY_W'($urandom), csr);
      end
    end
    drain_results();
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_output_backpressure();
    hold_request = 400;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_item(KIND_TICK, '0, '0);
      else send_item(KIND_POST, DELAY_W'($urandom_range(0, 2)), '0);
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    tx_idle_pct = 23;
    rx_idle_pct = 82;
    test_single_ops();
    test_full_and_burst();
    test_random_traffic(70);

    // then the other way round
    tx_idle_pct = 82;
    rx_idle_pct = 23;
    test_random_traffic(70);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(70);
    test_output_backpressure();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/teq_pkg.sv
design/teq_ctrl.sv
design/teq_datapath.sv
design/timed_event_queue_core.sv
bench/tb_top.sv
